@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle, outside of reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Implication whose consequence must hold in the next cycle, outside of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ design/ccad_pkg.sv @@
package ccad_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 8;

    localparam int VBUS_W      = 16;
    localparam int TICK_W      = 8;
    localparam int LEVEL_W     = 3;
    localparam int CONN_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [VBUS_W-1:0] VBUS_THRESHOLD_RESET = 16'd1000;
    localparam logic [TICK_W-1:0] ATTACH_TICKS_RESET   = 8'd3;
    localparam logic [TICK_W-1:0] DETACH_TICKS_RESET   = 8'd10;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_VBUS_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACH_TICKS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DETACH_TICKS   = 2'd2;

    // Connection codes.
    localparam logic [CONN_W-1:0] CONN_NONE = 2'd0;
    localparam logic [CONN_W-1:0] CONN_CC1  = 2'd1;
    localparam logic [CONN_W-1:0] CONN_CC2  = 2'd2;
    localparam logic [CONN_W-1:0] CONN_BAD  = 2'd3;

    // Level codes, in rising voltage order.
    localparam logic [LEVEL_W-1:0] LVL_0V00 = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_0V22 = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_0V45 = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_0V55 = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_0V66 = 3'd4;
    localparam logic [LEVEL_W-1:0] LVL_2V20 = 3'd5;

    // A connected port only watches the top comparator; an open port climbs
    // the ladder until the first comparator that is not tripped.
    function automatic logic [LEVEL_W-1:0] decode_level(input logic pin_high,
                                                        input logic [3:0] cmp,
                                                        input logic connected);
        logic [LEVEL_W-1:0] lvl;
        lvl = LVL_0V00;
        priority if (pin_high)  lvl = LVL_2V20;
        else if (connected)     lvl = cmp[3] ? LVL_0V66 : LVL_0V00;
        else if (!cmp[0])       lvl = LVL_0V00;
        else if (!cmp[1])       lvl = LVL_0V22;
        else if (!cmp[2])       lvl = LVL_0V45;
        else if (!cmp[3])       lvl = LVL_0V55;
        else                    lvl = LVL_0V66;
        return lvl;
    endfunction

    // Levels from 0.45 V up to 0.66 V.
    function automatic logic mid_band(input logic [LEVEL_W-1:0] lvl);
        return (lvl == LVL_0V45) || (lvl == LVL_0V55) || (lvl == LVL_0V66);
    endfunction

    // Levels that look like a sink pull-down seen against a high pin.
    function automatic logic rd_like(input logic [LEVEL_W-1:0] lvl);
        return (lvl == LVL_0V55) || (lvl == LVL_0V66);
    endfunction

    function automatic logic pair_is(input logic [LEVEL_W-1:0] a,
                                     input logic [LEVEL_W-1:0] b,
                                     input logic [LEVEL_W-1:0] x,
                                     input logic [LEVEL_W-1:0] y);
        return ((a == x) && (b == y)) || ((a == y) && (b == x));
    endfunction

endpackage

@@ design/cc_attach_detach_detector_core.sv @@
// Channel | Handshake           | Payload
// --------+---------------------+------------------------------------------------
// in      | in_valid / in_stall | vbus_mv, cc1_pin_high, cc1_compare,
//         |                     | cc2_pin_high, cc2_compare
// out     | out_valid/out_stall | connection, attach_pulse, detach_pulse,
//         |                     | cc_enable, cc1_level, cc2_level
// cfg     | cfg_wr_en           | cfg_wr_index, cfg_wr_data
//
// One poll tick is accepted every cycle while in_stall is low; its result is
// registered and shows on the output in the cycle after the transfer.
// The decode, the debounce counter update and the result all come from one
// combinational pass between the input ports and the result register.
// Reset clears the attach state, the counter and the CC enable, and loads the
// configuration registers with their defaults; no clearing pass is needed.
// While a result waits under out_stall, in_stall is raised in the same cycle.
module cc_attach_detach_detector_core #(
    parameter int COUNT_WIDTH = ccad_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_wr_en,
    input  logic [ccad_pkg::CFG_INDEX_W-1:0]    cfg_wr_index,
    input  logic [ccad_pkg::CFG_DATA_W-1:0]     cfg_wr_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ccad_pkg::VBUS_W-1:0]         vbus_mv,
    input  logic                                cc1_pin_high,
    input  logic [3:0]                          cc1_compare,
    input  logic                                cc2_pin_high,
    input  logic [3:0]                          cc2_compare,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ccad_pkg::CONN_W-1:0]         connection,
    output logic                                attach_pulse,
    output logic                                detach_pulse,
    output logic                                cc_enable,
    output logic [ccad_pkg::LEVEL_W-1:0]        cc1_level,
    output logic [ccad_pkg::LEVEL_W-1:0]        cc2_level
);

    localparam int CMP_W = (COUNT_WIDTH > ccad_pkg::TICK_W) ? COUNT_WIDTH : ccad_pkg::TICK_W;

    logic [ccad_pkg::VBUS_W-1:0]  vbus_threshold_reg;
    logic [ccad_pkg::TICK_W-1:0]  attach_ticks_reg;
    logic [ccad_pkg::TICK_W-1:0]  detach_ticks_reg;

    logic [ccad_pkg::CONN_W-1:0]  attached_line_reg;
    logic [ccad_pkg::CONN_W-1:0]  attached_line_next;
    logic [COUNT_WIDTH-1:0]       debounce_count_reg;
    logic [COUNT_WIDTH-1:0]       debounce_count_next;
    logic                         cc_enable_reg;
    logic                         cc_enable_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [ccad_pkg::CONN_W-1:0]  connection_reg;
    logic                         attach_pulse_reg;
    logic                         detach_pulse_reg;
    logic                         cc_enable_out_reg;
    logic [ccad_pkg::LEVEL_W-1:0] cc1_level_reg;
    logic [ccad_pkg::LEVEL_W-1:0] cc2_level_reg;

    logic                         in_xfer;
    logic                         connected;
    logic [ccad_pkg::LEVEL_W-1:0] lvl1;
    logic [ccad_pkg::LEVEL_W-1:0] lvl2;
    logic                         cond_attach;
    logic                         cond_hold;
    logic [COUNT_WIDTH-1:0]       count_inc;
    logic [CMP_W-1:0]             count_inc_ext;
    logic                         attach_hit;
    logic                         detach_hit;
    logic                         attach_now;
    logic                         detach_now;
    logic [ccad_pkg::CONN_W-1:0]  orientation;

    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vbus_threshold_reg <= ccad_pkg::VBUS_THRESHOLD_RESET;
            attach_ticks_reg   <= ccad_pkg::ATTACH_TICKS_RESET;
            detach_ticks_reg   <= ccad_pkg::DETACH_TICKS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_wr_index)
                ccad_pkg::REG_VBUS_THRESHOLD: vbus_threshold_reg <= cfg_wr_data;
                ccad_pkg::REG_ATTACH_TICKS:   attach_ticks_reg <= cfg_wr_data[ccad_pkg::TICK_W-1:0];
                ccad_pkg::REG_DETACH_TICKS:   detach_ticks_reg <= cfg_wr_data[ccad_pkg::TICK_W-1:0];
                default:                      ;
            endcase
        end
    end

    assign connected = attached_line_reg != ccad_pkg::CONN_NONE;
    assign lvl1      = ccad_pkg::decode_level(cc1_pin_high, cc1_compare, connected);
    assign lvl2      = ccad_pkg::decode_level(cc2_pin_high, cc2_compare, connected);

    // Qualifying pair for an open port. The override order matters.
    always_comb
    begin
        cond_attach = (ccad_pkg::mid_band(lvl1) &&
                       ((lvl2 == ccad_pkg::LVL_2V20) || (lvl2 <= ccad_pkg::LVL_0V22))) ||
                      (ccad_pkg::mid_band(lvl2) &&
                       ((lvl1 == ccad_pkg::LVL_2V20) || (lvl1 <= ccad_pkg::LVL_0V22)));
        if ((lvl1 == ccad_pkg::LVL_2V20) || (lvl2 == ccad_pkg::LVL_2V20))
            cond_attach = 1'b0;
        if ((ccad_pkg::rd_like(lvl1) && (lvl2 == ccad_pkg::LVL_2V20)) ||
            (ccad_pkg::rd_like(lvl2) && (lvl1 == ccad_pkg::LVL_2V20)))
            cond_attach = 1'b1;
        if (ccad_pkg::pair_is(lvl1, lvl2, ccad_pkg::LVL_0V00, ccad_pkg::LVL_2V20))
            cond_attach = 1'b0;
        if (ccad_pkg::pair_is(lvl1, lvl2, ccad_pkg::LVL_0V00, ccad_pkg::LVL_0V66))
            cond_attach = 1'b1;
    end

    // Pair that keeps a connected port attached.
    always_comb
    begin
        cond_hold = ccad_pkg::mid_band(lvl1) || ccad_pkg::mid_band(lvl2);
        if (ccad_pkg::pair_is(lvl1, lvl2, ccad_pkg::LVL_0V00, ccad_pkg::LVL_2V20))
            cond_hold = 1'b0;
        if (ccad_pkg::pair_is(lvl1, lvl2, ccad_pkg::LVL_0V00, ccad_pkg::LVL_0V66))
            cond_hold = 1'b1;
    end

    always_comb
    begin
        priority if (ccad_pkg::rd_like(lvl1) && (lvl2 == ccad_pkg::LVL_2V20))
            orientation = ccad_pkg::CONN_CC1;
        else if (ccad_pkg::rd_like(lvl2) && (lvl1 == ccad_pkg::LVL_2V20))
            orientation = ccad_pkg::CONN_CC2;
        else if (lvl1 > lvl2)
            orientation = ccad_pkg::CONN_CC1;
        else
            orientation = ccad_pkg::CONN_CC2;
    end

    // The counter saturates at its all-ones value.
    assign count_inc     = (&debounce_count_reg) ? debounce_count_reg
                                                 : debounce_count_reg + 1'b1;
    assign count_inc_ext = CMP_W'(count_inc);
    assign attach_hit    = count_inc_ext >= CMP_W'(attach_ticks_reg);
    assign detach_hit    = count_inc_ext >= CMP_W'(detach_ticks_reg);

    always_comb
    begin
        attached_line_next  = attached_line_reg;
        debounce_count_next = debounce_count_reg;
        cc_enable_next      = cc_enable_reg;
        attach_now          = 1'b0;
        detach_now          = 1'b0;
        if (vbus_mv < vbus_threshold_reg)
        begin
            if (connected)
            begin
                attached_line_next  = ccad_pkg::CONN_NONE;
                debounce_count_next = '0;
                detach_now          = 1'b1;
            end
        end
        else
        begin
            cc_enable_next = vbus_mv > vbus_threshold_reg;
            if (connected)
            begin
                debounce_count_next = cond_hold ? '0 : count_inc;
                if (!cond_hold && detach_hit)
                begin
                    attached_line_next  = ccad_pkg::CONN_NONE;
                    debounce_count_next = '0;
                    detach_now          = 1'b1;
                end
            end
            else
            begin
                debounce_count_next = cond_attach ? count_inc : '0;
                if (cond_attach && attach_hit)
                begin
                    attached_line_next  = orientation;
                    debounce_count_next = '0;
                    attach_now          = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attached_line_reg  <= ccad_pkg::CONN_NONE;
            debounce_count_reg <= '0;
            cc_enable_reg      <= 1'b0;
        end
        else if (in_xfer)
        begin
            attached_line_reg  <= attached_line_next;
            debounce_count_reg <= debounce_count_next;
            cc_enable_reg      <= cc_enable_next;
        end
    end

    always_comb
    begin
        if (in_xfer)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            connection_reg    <= attached_line_next;
            attach_pulse_reg  <= attach_now;
            detach_pulse_reg  <= detach_now;
            cc_enable_out_reg <= cc_enable_next;
            cc1_level_reg     <= lvl1;
            cc2_level_reg     <= lvl2;
        end
    end

    assign out_valid    = out_valid_reg;
    assign connection   = connection_reg;
    assign attach_pulse = attach_pulse_reg;
    assign detach_pulse = detach_pulse_reg;
    assign cc_enable    = cc_enable_out_reg;
    assign cc1_level    = cc1_level_reg;
    assign cc2_level    = cc2_level_reg;

endmodule

@@ design/ccad_checker.sv @@
`include "assert_macros.svh"

module ccad_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [ccad_pkg::CONN_W-1:0]      connection,
    input logic                             attach_pulse,
    input logic                             detach_pulse
);

    // Attach and detach never share a tick.
    `ASSERT_NOW(a_pulse_excl, clk, rst_n, out_valid, !(attach_pulse && detach_pulse))

    // An attach leaves the port connected, a detach leaves it open.
    `ASSERT_NOW(a_attach_conn, clk, rst_n, out_valid && attach_pulse, connection != ccad_pkg::CONN_NONE)
    `ASSERT_NOW(a_detach_open, clk, rst_n, out_valid && detach_pulse, connection == ccad_pkg::CONN_NONE)

    // The line code for both lines together is never produced.
    `ASSERT_NOW(a_conn_code, clk, rst_n, out_valid, connection != ccad_pkg::CONN_BAD)

    // A stalled result stays in place.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(connection))

endmodule

bind cc_attach_detach_detector_core ccad_checker u_ccad_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .connection   (connection),
    .attach_pulse (attach_pulse),
    .detach_pulse (detach_pulse)
);

@@ test/tb_cc_attach_detach_detector_core.sv @@
`timescale 1ns / 1ps

module tb_cc_attach_detach_detector_core;

    localparam int COUNT_W = ccad_pkg::COUNT_WIDTH_DEFAULT;
    localparam logic [ccad_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int IDLE_PERCENT = 37;

    typedef struct packed {
        logic [ccad_pkg::VBUS_W-1:0] vbus;
        logic                        pin1;
        logic [3:0]                  cmp1;
        logic                        pin2;
        logic [3:0]                  cmp2;
    } tick_t;

    typedef struct packed {
        logic [ccad_pkg::CONN_W-1:0]  conn;
        logic                         attach;
        logic                         detach;
        logic                         enable;
        logic [ccad_pkg::LEVEL_W-1:0] lvl1;
        logic [ccad_pkg::LEVEL_W-1:0] lvl2;
    } status_t;

    // Tracks the port state on every accepted poll tick and holds the
    // status words that the block still owes.
    class attach_tracker;
        logic [ccad_pkg::VBUS_W-1:0] vbus_threshold;
        logic [ccad_pkg::TICK_W-1:0] attach_ticks;
        logic [ccad_pkg::TICK_W-1:0] detach_ticks;
        logic [ccad_pkg::CONN_W-1:0] line;
        logic [COUNT_W-1:0]          count;
        logic                        enable;
        status_t                     expected_status[$];
        int                          failures;

        function new();
            vbus_threshold = ccad_pkg::VBUS_THRESHOLD_RESET;
            attach_ticks   = ccad_pkg::ATTACH_TICKS_RESET;
            detach_ticks   = ccad_pkg::DETACH_TICKS_RESET;
            line           = ccad_pkg::CONN_NONE;
            count          = '0;
            enable         = 1'b0;
            failures       = 0;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        function void apply_reg(logic [ccad_pkg::CFG_INDEX_W-1:0] idx,
                                logic [ccad_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                ccad_pkg::REG_VBUS_THRESHOLD: vbus_threshold = data[ccad_pkg::VBUS_W-1:0];
                ccad_pkg::REG_ATTACH_TICKS:   attach_ticks   = data[ccad_pkg::TICK_W-1:0];
                ccad_pkg::REG_DETACH_TICKS:   detach_ticks   = data[ccad_pkg::TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [ccad_pkg::LEVEL_W-1:0] line_level(logic pin, logic [3:0] cmp,
                                                          logic conn);
            logic [ccad_pkg::LEVEL_W-1:0] lvl;
            bit                           stop;
            int                           i;
            lvl  = ccad_pkg::LVL_0V00;
            stop = 1'b0;
            if (pin)
                return ccad_pkg::LVL_2V20;
            if (conn)
                return cmp[3] ? ccad_pkg::LVL_0V66 : ccad_pkg::LVL_0V00;
            for (i = 0; i < 4; i++)
            begin
                if (!stop)
                begin
                    if (cmp[i])
                        lvl = lvl + 1'b1;
                    else
                        stop = 1'b1;
                end
            end
            return lvl;
        endfunction

        function bit in_mid(logic [ccad_pkg::LEVEL_W-1:0] lvl);
            return (lvl >= ccad_pkg::LVL_0V45) && (lvl <= ccad_pkg::LVL_0V66);
        endfunction

        function bit sink_pull(logic [ccad_pkg::LEVEL_W-1:0] lvl);
            return (lvl == ccad_pkg::LVL_0V55) || (lvl == ccad_pkg::LVL_0V66);
        endfunction

        function bit both_of(logic [ccad_pkg::LEVEL_W-1:0] a, logic [ccad_pkg::LEVEL_W-1:0] b,
                             logic [ccad_pkg::LEVEL_W-1:0] x, logic [ccad_pkg::LEVEL_W-1:0] y);
            return ((a == x) && (b == y)) || ((a == y) && (b == x));
        endfunction

        function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] c);
            return (c == {COUNT_W{1'b1}}) ? c : c + 1'b1;
        endfunction

        function void note_tick(tick_t t);
            status_t                      s;
            logic                         conn;
            logic [ccad_pkg::LEVEL_W-1:0] l1;
            logic [ccad_pkg::LEVEL_W-1:0] l2;
            bit                           qual;
            conn     = (line != ccad_pkg::CONN_NONE);
            l1       = line_level(t.pin1, t.cmp1, conn);
            l2       = line_level(t.pin2, t.cmp2, conn);
            s.attach = 1'b0;
            s.detach = 1'b0;
            if (t.vbus < vbus_threshold)
            begin
                // Losing VBUS drops a connected port at once; the CC enable holds.
                if (conn)
                begin
                    line     = ccad_pkg::CONN_NONE;
                    count    = '0;
                    s.detach = 1'b1;
                end
            end
            else
            begin
                enable = (t.vbus > vbus_threshold);
                if (conn)
                begin
                    qual = in_mid(l1) || in_mid(l2);
                    if (both_of(l1, l2, ccad_pkg::LVL_0V00, ccad_pkg::LVL_2V20))
                        qual = 1'b0;
                    if (both_of(l1, l2, ccad_pkg::LVL_0V00, ccad_pkg::LVL_0V66))
                        qual = 1'b1;
                    count = qual ? '0 : bump(count);
                    if (!qual && count >= detach_ticks)
                    begin
                        line     = ccad_pkg::CONN_NONE;
                        count    = '0;
                        s.detach = 1'b1;
                    end
                end
                else
                begin
                    qual = (in_mid(l1) &&
                            (l2 == ccad_pkg::LVL_2V20 || l2 <= ccad_pkg::LVL_0V22)) ||
                           (in_mid(l2) &&
                            (l1 == ccad_pkg::LVL_2V20 || l1 <= ccad_pkg::LVL_0V22));
                    if (l1 == ccad_pkg::LVL_2V20 || l2 == ccad_pkg::LVL_2V20)
                        qual = 1'b0;
                    if (both_of(l1, l2, ccad_pkg::LVL_0V55, ccad_pkg::LVL_2V20) ||
                        both_of(l1, l2, ccad_pkg::LVL_0V66, ccad_pkg::LVL_2V20))
                        qual = 1'b1;
                    if (both_of(l1, l2, ccad_pkg::LVL_0V00, ccad_pkg::LVL_2V20))
                        qual = 1'b0;
                    if (both_of(l1, l2, ccad_pkg::LVL_0V00, ccad_pkg::LVL_0V66))
                        qual = 1'b1;
                    count = qual ? bump(count) : '0;
                    if (qual && count >= attach_ticks)
                    begin
                        if (sink_pull(l1) && l2 == ccad_pkg::LVL_2V20)
                            line = ccad_pkg::CONN_CC1;
                        else if (sink_pull(l2) && l1 == ccad_pkg::LVL_2V20)
                            line = ccad_pkg::CONN_CC2;
                        else
                            line = (l1 > l2) ? ccad_pkg::CONN_CC1 : ccad_pkg::CONN_CC2;
                        count    = '0;
                        s.attach = 1'b1;
                    end
                end
            end
            s.conn   = line;
            s.enable = enable;
            s.lvl1   = l1;
            s.lvl2   = l2;
            expected_status.push_back(s);
        endfunction

        function void check_status(status_t got);
            status_t want;
            bit      bad;
            if (expected_status.size() == 0)
            begin
                flag($sformatf("unexpected result: conn=%0d att=%0d det=%0d en=%0d l1=%0d l2=%0d",
                               got.conn, got.attach, got.detach, got.enable,
                               got.lvl1, got.lvl2));
                return;
            end
            want = expected_status.pop_front();
            bad  = (got.conn !== want.conn) || (got.attach !== want.attach) ||
                   (got.detach !== want.detach) || (got.enable !== want.enable) ||
                   (got.lvl1 !== want.lvl1) || (got.lvl2 !== want.lvl2);
            if (bad)
                flag($sformatf({"mismatch: expected conn=%0d att=%0d det=%0d en=%0d",
                                " l1=%0d l2=%0d,",
                                " got conn=%0d att=%0d det=%0d en=%0d l1=%0d l2=%0d"},
                               want.conn, want.attach, want.detach, want.enable,
                               want.lvl1, want.lvl2, got.conn, got.attach, got.detach,
                               got.enable, got.lvl1, got.lvl2));
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [ccad_pkg::CFG_INDEX_W-1:0] cfg_wr_index = '0;
    logic [ccad_pkg::CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic [ccad_pkg::VBUS_W-1:0]      vbus_mv = '0;
    logic                             cc1_pin_high = 1'b0;
    logic [3:0]                       cc1_compare = '0;
    logic                             cc2_pin_high = 1'b0;
    logic [3:0]                       cc2_compare = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [ccad_pkg::CONN_W-1:0]      connection;
    logic                             attach_pulse;
    logic                             detach_pulse;
    logic                             cc_enable;
    logic [ccad_pkg::LEVEL_W-1:0]     cc1_level;
    logic [ccad_pkg::LEVEL_W-1:0]     cc2_level;

    attach_tracker                    tracker = new();
    bit                               idle_on = 1'b1;
    logic [ccad_pkg::VBUS_W-1:0]      vbus_limit = ccad_pkg::VBUS_THRESHOLD_RESET;
    tick_t                            seen_tick;
    status_t                          seen_status;

    cc_attach_detach_detector_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .vbus_mv      (vbus_mv),
        .cc1_pin_high (cc1_pin_high),
        .cc1_compare  (cc1_compare),
        .cc2_pin_high (cc2_pin_high),
        .cc2_compare  (cc2_compare),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .connection   (connection),
        .attach_pulse (attach_pulse),
        .detach_pulse (detach_pulse),
        .cc_enable    (cc_enable),
        .cc1_level    (cc1_level),
        .cc2_level    (cc2_level)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen_status = {connection, attach_pulse, detach_pulse, cc_enable,
                               cc1_level, cc2_level};
                tracker.check_status(seen_status);
            end
            if (in_valid && !in_stall)
            begin
                seen_tick = {vbus_mv, cc1_pin_high, cc1_compare, cc2_pin_high, cc2_compare};
                tracker.note_tick(seen_tick);
            end
        end
    end

    // Presents one poll tick and returns at the edge where its transfer happens.
    task automatic send_tick(logic [ccad_pkg::VBUS_W-1:0] vbus, logic p1, logic [3:0] c1,
                             logic p2, logic [3:0] c2);
        while (idle_on && ($urandom_range(99) < IDLE_PERCENT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        vbus_mv      <= vbus;
        cc1_pin_high <= p1;
        cc1_compare  <= c1;
        cc2_pin_high <= p2;
        cc2_compare  <= c2;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Holds the sender off until every outstanding status word has come back.
    // The first edge lets the last transfer reach the tracker.
    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_status.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [ccad_pkg::CFG_INDEX_W-1:0] idx,
                             logic [ccad_pkg::CFG_DATA_W-1:0] data);
        settle();
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.apply_reg(idx, data);
        if (idx == ccad_pkg::REG_VBUS_THRESHOLD)
            vbus_limit = data;
    endtask

    // Upper data bits of the tick registers are junk that the block must drop.
    task automatic set_regs(logic [ccad_pkg::VBUS_W-1:0] thr, logic [ccad_pkg::TICK_W-1:0] att,
                            logic [ccad_pkg::TICK_W-1:0] det);
        write_reg(ccad_pkg::REG_VBUS_THRESHOLD, thr);
        write_reg(ccad_pkg::REG_ATTACH_TICKS, {8'($urandom_range(255)), att});
        write_reg(ccad_pkg::REG_DETACH_TICKS, {8'($urandom_range(255)), det});
    endtask

    function automatic logic [ccad_pkg::VBUS_W-1:0] pick_vbus();
        int p;
        p = $urandom_range(99);
        if (p < 10 && vbus_limit != 0)
            return 16'($urandom_range(vbus_limit - 1, 0));
        else if (p < 15 || vbus_limit == 16'hFFFF)
            return vbus_limit;
        else
            return 16'($urandom_range(65535, vbus_limit + 1));
    endfunction

    // One CC line as {pin, comparators}, biased towards the levels that matter.
    function automatic logic [4:0] line_pattern();
        int p;
        p = $urandom_range(99);
        if (p < 25)
            return 5'b0_0000;
        else if (p < 55)
        begin
            case ($urandom_range(2))
                0:       return 5'b0_0011;
                1:       return 5'b0_0111;
                default: return 5'b0_1111;
            endcase
        end
        else if (p < 70)
            return {1'b1, 4'($urandom_range(15))};
        else if (p < 85)
            return {1'b0, 4'($urandom_range(15))};
        else
            return 5'($urandom_range(31));
    endfunction

    // Runs of a held CC pattern let the debounce counters reach their targets.
    task automatic run_phase(int items, int max_run);
        int         done;
        int         run;
        int         k;
        logic [4:0] a;
        logic [4:0] b;
        done = 0;
        while (done < items)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_tick(16'($urandom_range(65535)), 1'($urandom_range(1)),
                          4'($urandom_range(15)), 1'($urandom_range(1)),
                          4'($urandom_range(15)));
                done++;
            end
            else
            begin
                run = ($urandom_range(99) < 25) ? $urandom_range(max_run, 1)
                                                : $urandom_range(12, 1);
                a = line_pattern();
                b = line_pattern();
                for (k = 0; k < run && done < items; k++)
                begin
                    send_tick(pick_vbus(), a[4], a[3:0], b[4], b[3:0]);
                    done++;
                end
            end
        end
    endtask

    task automatic directed_ticks();
        send_tick(16'd0, 1'b0, 4'h0, 1'b0, 4'h0);
        send_tick(16'hFFFF, 1'b1, 4'hF, 1'b1, 4'hF);
        // At the threshold the counters run but the CC enable stays low.
        send_tick(16'd1000, 1'b0, 4'b0101, 1'b0, 4'b1011);
        send_tick(16'd1001, 1'b0, 4'h0, 1'b0, 4'hF);
        send_tick(16'd1001, 1'b0, 4'h0, 1'b0, 4'hF);
        send_tick(16'd5000, 1'b0, 4'h7, 1'b0, 4'h8);
        send_tick(16'd5000, 1'b1, 4'h0, 1'b0, 4'h0);
        send_tick(16'd999, 1'b0, 4'hF, 1'b0, 4'h0);
        repeat (3) send_tick(16'd2000, 1'b0, 4'h7, 1'b1, 4'h0);
        send_tick(16'd2000, 1'b0, 4'hF, 1'b1, 4'h0);
        write_reg(ccad_pkg::REG_DETACH_TICKS, 16'hAB01);
        send_tick(16'd3000, 1'b1, 4'hF, 1'b0, 4'h0);
        // A zero tick count behaves like one.
        write_reg(ccad_pkg::REG_ATTACH_TICKS, 16'h0000);
        send_tick(16'd3000, 1'b0, 4'h3, 1'b0, 4'h1);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_tick(16'd3000, 1'b0, 4'h0, 1'b0, 4'h8);
        send_tick(16'd0, 1'b0, 4'h0, 1'b0, 4'h0);
        send_tick(16'd3000, 1'b1, 4'h0, 1'b0, 4'h7);
        send_tick(16'hFFFF, 1'b0, 4'hF, 1'b0, 4'hF);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_ticks();

        set_regs(16'd1000, 8'd3, 8'd10);
        run_phase(250, 20);
        set_regs(16'd0, 8'd1, 8'd1);
        run_phase(120, 5);
        settle();
        run_phase(120, 5);
        set_regs(16'hFFFF, 8'd1, 8'd2);
        run_phase(200, 8);
        set_regs(16'($urandom_range(8000)), 8'd255, 8'd255);
        run_phase(300, 280);
        set_regs(16'($urandom_range(8000)), 8'd0, 8'd0);
        run_phase(200, 6);
        idle_on = 1'b0;
        set_regs(16'($urandom_range(8000)), 8'($urandom_range(20, 1)),
                 8'($urandom_range(30, 1)));
        run_phase(300, 30);
        idle_on = 1'b1;

        settle();
        if (tracker.expected_status.size() != 0)
            tracker.flag($sformatf("%0d results never arrived",
                                   tracker.expected_status.size()));
        if (tracker.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ cc_attach_detach_detector_core.f @@
+incdir+design
design/ccad_pkg.sv
design/cc_attach_detach_detector_core.sv
design/ccad_checker.sv
test/tb_cc_attach_detach_detector_core.sv
